FILE: src/dsfp_pkg.sv
// shared constants and types for the dle stuffed frame parser
// no dependencies; modules refer to it by scoped names
package dsfp_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned PAYLOAD_BYTES   = 7;
    localparam int unsigned COUNT_W         = 4;
    localparam int unsigned MIN_LAST_INDEX  = 10;  // index of the final byte of a shortest frame
    localparam int unsigned FIRST_UNSTUFF   = 4;
    localparam int unsigned START_INDEX     = 1;
    localparam int unsigned END_MIN_INDEX   = 3;
    localparam int unsigned CFG_ADDR_W      = 2;
    localparam int unsigned RESULT_W        = 56;

    localparam logic [BYTE_W-1:0]  DLE_RESET     = 8'h10;
    localparam logic [BYTE_W-1:0]  STX_RESET     = 8'h02;
    localparam logic [BYTE_W-1:0]  ETX_RESET     = 8'h03;
    localparam logic [BYTE_W-1:0]  MAX_LEN_RESET = 8'd18;
    localparam logic [BYTE_W-1:0]  INDEX_MAX     = 8'hff;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DLE_CODE      = 2'd0,
        CFG_STX_CODE      = 2'd1,
        CFG_ETX_CODE      = 2'd2,
        CFG_MAX_FRAME_LEN = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]       check_word;
        logic [31:0]       param_value;
        logic [BYTE_W-1:0] param_id;
    } result_data_t;

    typedef struct packed {
        logic         frame_ok;
        result_data_t data;
    } result_t;

endpackage

FILE: src/dle_stuffed_frame_parser_unit.sv
// A frame's result word is registered on m_, or in the skid while m_ stalls.
// One raw byte per cycle while the skid is empty; byte checks and un-stuffing are combinational.
// A two-entry output register (main plus skid) lets bytes keep flowing while a result waits.
// Reset (aresetn low, synchronous): frame state and output valids clear, codes go to
// DLE 0x10, STX 0x02, ETX 0x03 and max length 18; the payload store is not cleared.
module dle_stuffed_frame_parser_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [dsfp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dsfp_pkg::BYTE_W-1:0]         cfg_wdata,
    // raw byte stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dsfp_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] raw_byte
    input  logic                                s_tlast,   // frame_end
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dsfp_pkg::RESULT_W-1:0]       m_tdata,   // [7:0] param_id, [39:8] param_value,
                                                           // [55:40] check_word
    output logic [0:0]                          m_tuser    // [0] frame_ok
);

    localparam int unsigned BW = dsfp_pkg::BYTE_W;
    localparam int unsigned CW = dsfp_pkg::COUNT_W;

    // configuration registers
    logic [BW-1:0] dle_code_reg, stx_code_reg, etx_code_reg, max_len_reg;

    // frame state
    logic [BW-1:0] byte_index_reg, byte_index_next;
    logic [BW-1:0] held0_reg, held0_next, held1_reg, held1_next;
    logic          start_good_reg, start_good_next;
    logic          end_found_reg, end_found_next;
    logic          escape_reg, escape_next;
    logic [CW-1:0] payload_count_reg, payload_count_next;
    logic [BW-1:0] payload_reg [dsfp_pkg::PAYLOAD_BYTES];
    logic [BW-1:0] payload_next [dsfp_pkg::PAYLOAD_BYTES];

    // output register and skid
    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    dsfp_pkg::result_t   out_reg, out_next, skid_reg, skid_next;
    dsfp_pkg::result_t   result;

    logic s_accept, res_valid, frame_ok;
    logic unstuff_en, drop_byte;

    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign res_valid = s_accept && s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dle_code_reg <= dsfp_pkg::DLE_RESET;
            stx_code_reg <= dsfp_pkg::STX_RESET;
            etx_code_reg <= dsfp_pkg::ETX_RESET;
            max_len_reg  <= dsfp_pkg::MAX_LEN_RESET;
        end else if (cfg_we) begin
            unique case (dsfp_pkg::cfg_index_t'(cfg_addr))
                dsfp_pkg::CFG_DLE_CODE:      dle_code_reg <= cfg_wdata;
                dsfp_pkg::CFG_STX_CODE:      stx_code_reg <= cfg_wdata;
                dsfp_pkg::CFG_ETX_CODE:      etx_code_reg <= cfg_wdata;
                dsfp_pkg::CFG_MAX_FRAME_LEN: max_len_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-byte checks and un-stuffing
    always_comb begin
        byte_index_next    = byte_index_reg;
        held0_next         = held0_reg;
        held1_next         = held1_reg;
        start_good_next    = start_good_reg;
        end_found_next     = end_found_reg;
        escape_next        = escape_reg;
        payload_count_next = payload_count_reg;
        payload_next       = payload_reg;
        unstuff_en         = 1'b0;
        drop_byte          = 1'b0;

        if (s_accept) begin
            if (byte_index_reg == BW'(dsfp_pkg::START_INDEX)) begin
                start_good_next = (held0_reg == dle_code_reg) && (s_tdata == stx_code_reg);
            end
            if (byte_index_reg >= BW'(dsfp_pkg::END_MIN_INDEX) && held0_reg == dle_code_reg &&
                s_tdata == etx_code_reg && held1_reg != dle_code_reg) begin
                end_found_next = 1'b1;
            end

            // bytes enter the un-stuffer two places late
            unstuff_en = byte_index_reg >= BW'(dsfp_pkg::FIRST_UNSTUFF);
            drop_byte  = !escape_reg && held1_reg == dle_code_reg;
            if (unstuff_en) begin
                if (drop_byte) begin
                    escape_next = 1'b1;
                end else begin
                    escape_next = 1'b0;
                    if (payload_count_reg < CW'(dsfp_pkg::PAYLOAD_BYTES)) begin
                        payload_next[payload_count_reg[2:0]] = held1_reg;
                        payload_count_next = payload_count_reg + CW'(1);
                    end else begin
                        payload_count_next = CW'(dsfp_pkg::PAYLOAD_BYTES + 1);
                    end
                end
            end

            held1_next = held0_reg;
            held0_next = s_tdata;
            if (byte_index_reg != dsfp_pkg::INDEX_MAX) begin
                byte_index_next = byte_index_reg + BW'(1);
            end
        end

        // length from 11 up to max_frame_len, saturated index never passes
        frame_ok = byte_index_reg >= BW'(dsfp_pkg::MIN_LAST_INDEX) &&
                   byte_index_reg < max_len_reg && start_good_next && end_found_next &&
                   payload_count_next == CW'(dsfp_pkg::PAYLOAD_BYTES);

        result.frame_ok = frame_ok;
        if (frame_ok) begin
            result.data.param_id    = payload_next[0];
            result.data.param_value = {payload_next[4], payload_next[3],
                                       payload_next[2], payload_next[1]};
            result.data.check_word  = {payload_next[6], payload_next[5]};
        end else begin
            result.data = '0;
        end

        if (res_valid) begin
            byte_index_next    = '0;
            held0_next         = '0;
            held1_next         = '0;
            start_good_next    = 1'b0;
            end_found_next     = 1'b0;
            escape_next        = 1'b0;
            payload_count_next = '0;
        end
    end

    // output register with skid
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_next       = result;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg    <= '0;
            held0_reg         <= '0;
            held1_reg         <= '0;
            start_good_reg    <= 1'b0;
            end_found_reg     <= 1'b0;
            escape_reg        <= 1'b0;
            payload_count_reg <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            byte_index_reg    <= byte_index_next;
            held0_reg         <= held0_next;
            held1_reg         <= held1_next;
            start_good_reg    <= start_good_next;
            end_found_reg     <= end_found_next;
            escape_reg        <= escape_next;
            payload_count_reg <= payload_count_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
        out_reg     <= out_next;
        skid_reg    <= skid_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.data;
    assign m_tuser[0] = out_reg.frame_ok;

    // skid only fills behind a waiting word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        payload_count_reg <= CW'(dsfp_pkg::PAYLOAD_BYTES + 1))
        else $error("payload count out of range");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("failed frame carries nonzero fields");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (byte_index_reg == '0 && payload_count_reg == '0))
        else $error("frame state not cleared after last byte");

    a_early_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_index_reg < BW'(dsfp_pkg::FIRST_UNSTUFF + 1)) |->
            (payload_count_reg == '0 && !escape_reg))
        else $error("un-stuffer active before first payload byte");

endmodule
